/* sv/fourier_grid_truncate_pack_core_assert.svh */
// Assertion macros used by the checker of the grid truncation core.
// Depends on nothing; included by the checker file.
`ifndef FOURIER_GRID_TRUNCATE_PACK_CORE_ASSERT_SVH
`define FOURIER_GRID_TRUNCATE_PACK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define FGTP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define FGTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/fgtp_pkg.sv */
// Shared types, constants and helper functions of the grid truncation core.
// Depends on nothing; imported by every module of the block except the FIFO.
`default_nettype none

package fgtp_pkg;

    localparam int DIM_W          = 8;
    localparam int INV_W          = 48;
    localparam int IDX_W          = 21;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 48;
    localparam int HALF_W         = 24;
    localparam int SQ_W           = 18;
    localparam int DEF_MAX_DIM    = 128;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int OUT_DEPTH      = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_COARSE_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COARSE_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COARSE_Z = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FINE_X   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FINE_Y   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FINE_Z   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_SIZE = 3'd6;

    localparam logic [DIM_W-1:0] RST_COARSE   = 8'd16;
    localparam logic [DIM_W-1:0] RST_FINE     = 8'd32;
    localparam logic [INV_W-1:0] RST_INV_SIZE = 48'd8589934592;

    typedef struct packed {
        logic [DIM_W-1:0] coarse_x;
        logic [DIM_W-1:0] coarse_y;
        logic [DIM_W-1:0] coarse_z;
        logic [DIM_W-1:0] fine_x;
        logic [DIM_W-1:0] fine_y;
        logic [DIM_W-1:0] fine_z;
    } fgtp_dims_t;

    // Effective dimension: bit 0 cleared, clamped to at least 2 and at most top.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
                                                 input logic [DIM_W:0]   top);
        logic [DIM_W-1:0] d;
        d = {raw[DIM_W-1:1], 1'b0};
        if (d < DIM_W'(2)) begin
            d = DIM_W'(2);
        end
        if ({1'b0, d} > top) begin
            d = top[DIM_W-1:0];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* sv/fourier_grid_truncate_pack_core.sv */
// Top level of the Fourier grid spectral truncation core: configuration
// registers, front end, queue, back end and output buffer. Depends on fgtp_pkg.
`default_nettype none

// The fine grid streams in one complex coefficient per word in raster order
// (x slowest, z fastest). Each word inside the coarse box yields one output
// word with its coarse raster index and the value scaled by inv_size / 2^48,
// rounded and saturated (zero outside the cutoff sphere if the coarse dims
// are equal); words outside the box yield nothing. The core takes one word
// per cycle unless the output stalls; a result passes through the two front
// pipeline stages, the queue, the three split multiplier stages and the
// output buffer. Input is throttled by credit on the four-entry queue and
// output by credit on the eight-entry output buffer. Dimension writes
// restart the grid position at zero; write configuration only while idle.

module fourier_grid_truncate_pack_core #(
    parameter int MAX_DIM    = fgtp_pkg::DEF_MAX_DIM,
    parameter int DATA_WIDTH = fgtp_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    // value_re, value_im
    input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]            s_tdata,
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    // coarse_index, out_re, out_im
    output logic [((fgtp_pkg::IDX_W+2*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    input  wire logic                                         cfg_valid,
    output logic                                              cfg_ready,
    input  wire logic [fgtp_pkg::CFG_INDEX_W-1:0]             cfg_index,
    input  wire logic [fgtp_pkg::CFG_DATA_W-1:0]              cfg_data
);

    import fgtp_pkg::*;

    localparam int QW     = IDX_W + 1 + 2 * DATA_WIDTH;
    localparam int OW     = IDX_W + 2 * DATA_WIDTH;
    localparam int M_W    = ((IDX_W + 2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    fgtp_dims_t       dims_reg, dims_next;
    logic [INV_W-1:0] inv_reg, inv_next;
    logic             restart;
    logic             cfg_write;

    logic              q_push, q_pop, q_empty;
    logic [QW-1:0]     q_wdata, q_rdata;
    logic [QCNT_W-1:0] q_count;
    logic              o_push, o_empty;
    logic [OW-1:0]     o_wdata, o_rdata;
    logic [OCNT_W-1:0] o_count;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        dims_next = dims_reg;
        inv_next  = inv_reg;
        restart   = 1'b0;
        if (cfg_write) begin
            unique case (cfg_index)
                REG_COARSE_X: begin
                    dims_next.coarse_x = cfg_data[DIM_W-1:0];
                    restart = 1'b1;
                end
                REG_COARSE_Y: begin
                    dims_next.coarse_y = cfg_data[DIM_W-1:0];
                    restart = 1'b1;
                end
                REG_COARSE_Z: begin
                    dims_next.coarse_z = cfg_data[DIM_W-1:0];
                    restart = 1'b1;
                end
                REG_FINE_X: begin
                    dims_next.fine_x = cfg_data[DIM_W-1:0];
                    restart = 1'b1;
                end
                REG_FINE_Y: begin
                    dims_next.fine_y = cfg_data[DIM_W-1:0];
                    restart = 1'b1;
                end
                REG_FINE_Z: begin
                    dims_next.fine_z = cfg_data[DIM_W-1:0];
                    restart = 1'b1;
                end
                REG_INV_SIZE: begin
                    inv_next = cfg_data[INV_W-1:0];
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg.coarse_x <= RST_COARSE;
            dims_reg.coarse_y <= RST_COARSE;
            dims_reg.coarse_z <= RST_COARSE;
            dims_reg.fine_x   <= RST_FINE;
            dims_reg.fine_y   <= RST_FINE;
            dims_reg.fine_z   <= RST_FINE;
            inv_reg           <= RST_INV_SIZE;
        end else begin
            dims_reg <= dims_next;
            inv_reg  <= inv_next;
        end
    end

    fgtp_front #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .QDEPTH     (QUEUE_DEPTH),
        .QW         (QW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dims     (dims_reg),
        .restart  (restart),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_re    (s_tdata[DATA_WIDTH-1:0]),
        .in_im    (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    fgtp_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty),
        .count     (q_count)
    );

    fgtp_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .ODEPTH     (OUT_DEPTH),
        .QW         (QW),
        .OW         (OW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .inv_size (inv_reg),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .o_count  (o_count),
        .o_push   (o_push),
        .o_data   (o_wdata)
    );

    fgtp_fifo #(
        .WIDTH (OW),
        .DEPTH (OUT_DEPTH)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (o_push),
        .push_data (o_wdata),
        .pop       (m_tvalid && m_tready),
        .pop_data  (o_rdata),
        .empty     (o_empty),
        .count     (o_count)
    );

    assign m_tvalid = !o_empty;
    assign m_tdata  = M_W'(o_rdata);

endmodule

`default_nettype wire

/* sv/fgtp_fifo.sv */
// Small register-based FIFO used as the front-to-back queue and output buffer.
// Depends on nothing; DEPTH must be a power of two.
`default_nettype none

module fgtp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           pop_data,
    output logic                            empty,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push  = push && (count_reg != CW'(DEPTH));
    assign do_pop   = pop && (count_reg != '0);
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* sv/fgtp_front.sv */
// Front end: grid position counters, frequency folding, box and cutoff tests,
// and coarse index computation. Depends on fgtp_pkg; feeds the queue.
`default_nettype none

module fgtp_front #(
    parameter int MAX_DIM    = fgtp_pkg::DEF_MAX_DIM,
    parameter int DATA_WIDTH = fgtp_pkg::DEF_DATA_WIDTH,
    parameter int QDEPTH     = fgtp_pkg::QUEUE_DEPTH,
    parameter int QW         = fgtp_pkg::IDX_W + 1 + 2 * DATA_WIDTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire fgtp_pkg::fgtp_dims_t        dims,
    input  wire logic                        restart,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [DATA_WIDTH-1:0]       in_re,
    input  wire logic [DATA_WIDTH-1:0]       in_im,
    input  wire logic [$clog2(QDEPTH+1)-1:0] q_count,
    output logic                             q_push,
    output logic      [QW-1:0]               q_data
);

    import fgtp_pkg::*;

    localparam int POS_W = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam int SF_W  = DIM_W + 2;
    localparam int TOP   = (MAX_DIM / 2) * 2;
    localparam logic [DIM_W:0] TOP_DIM = (DIM_W + 1)'(TOP);

    typedef struct packed {
        logic             in_box;
        logic [DIM_W-1:0] cpos;
        logic [DIM_W-1:0] mag;
    } axis_t;

    function automatic axis_t map_axis(input logic [DIM_W-1:0] p,
                                       input logic [DIM_W-1:0] f,
                                       input logic [DIM_W-1:0] c);
        axis_t                   r;
        logic signed [SF_W-1:0]  fq;
        logic signed [SF_W-1:0]  h;
        logic signed [SF_W-1:0]  cp;
        logic signed [SF_W-1:0]  ab;
        h  = $signed({3'b000, c[DIM_W-1:1]});
        if (p < {1'b0, f[DIM_W-1:1]}) begin
            fq = $signed({2'b00, p});
        end else begin
            fq = $signed({2'b00, p}) - $signed({2'b00, f});
        end
        cp = fq[SF_W-1] ? fq + $signed({2'b00, c}) : fq;
        ab = fq[SF_W-1] ? -fq : fq;
        r.in_box = (fq >= -h) && (fq < h);
        r.cpos   = cp[DIM_W-1:0];
        r.mag    = ab[DIM_W-1:0];
        return r;
    endfunction

    logic [DIM_W-1:0] cx, cy, cz, fx, fy, fz;
    logic [POS_W-1:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic             accept;
    logic [DIM_W-1:0] z_inc, y_inc, x_inc;
    axis_t            ax, ay, az;

    logic                  v1_reg, v2_reg;
    axis_t                 ax1_reg, ay1_reg, az1_reg;
    logic [DATA_WIDTH-1:0] re1_reg, im1_reg, re2_reg, im2_reg;
    logic                  box2_reg, keep2_reg;
    logic [2*DIM_W-1:0]    rowp2_reg;
    logic [DIM_W-1:0]      cpz2_reg;

    logic [2*DIM_W-1:0]    rowp;
    logic [SQ_W-1:0]       sq;
    logic [2*DIM_W-1:0]    hsq;
    logic                  keep;
    logic                  dims_equal;
    logic [3*DIM_W-1:0]    idx_full;
    logic [CNT_W:0]        load;

    always_comb begin
        cx = eff_dim(dims.coarse_x, TOP_DIM);
        cy = eff_dim(dims.coarse_y, TOP_DIM);
        cz = eff_dim(dims.coarse_z, TOP_DIM);
        fx = eff_dim(dims.fine_x, TOP_DIM);
        fy = eff_dim(dims.fine_y, TOP_DIM);
        fz = eff_dim(dims.fine_z, TOP_DIM);
    end

    assign load     = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(v1_reg) + (CNT_W + 1)'(v2_reg);
    assign in_ready = (load < (CNT_W + 1)'(QDEPTH));
    assign accept   = in_valid && in_ready;

    assign ax = map_axis(DIM_W'(px_reg), fx, cx);
    assign ay = map_axis(DIM_W'(py_reg), fy, cy);
    assign az = map_axis(DIM_W'(pz_reg), fz, cz);

    always_comb begin
        z_inc   = DIM_W'(pz_reg) + DIM_W'(1);
        y_inc   = DIM_W'(py_reg) + DIM_W'(1);
        x_inc   = DIM_W'(px_reg) + DIM_W'(1);
        px_next = px_reg;
        py_next = py_reg;
        pz_next = pz_reg;
        if (restart) begin
            px_next = '0;
            py_next = '0;
            pz_next = '0;
        end else if (accept) begin
            if (z_inc >= fz) begin
                pz_next = '0;
                if (y_inc >= fy) begin
                    py_next = '0;
                    px_next = (x_inc >= fx) ? '0 : x_inc[POS_W-1:0];
                end else begin
                    py_next = y_inc[POS_W-1:0];
                end
            end else begin
                pz_next = z_inc[POS_W-1:0];
            end
        end
    end

    always_comb begin
        dims_equal = (cx == cy) && (cx == cz);
        rowp = (2 * DIM_W)'(ax1_reg.cpos) * (2 * DIM_W)'(cy) + (2 * DIM_W)'(ay1_reg.cpos);
        sq   = SQ_W'(ax1_reg.mag) * SQ_W'(ax1_reg.mag) + SQ_W'(ay1_reg.mag) * SQ_W'(ay1_reg.mag)
             + SQ_W'(az1_reg.mag) * SQ_W'(az1_reg.mag);
        hsq  = (2 * DIM_W)'(cx[DIM_W-1:1]) * (2 * DIM_W)'(cx[DIM_W-1:1]);
        keep = !dims_equal || (sq <= SQ_W'(hsq));
        idx_full = (3 * DIM_W)'(rowp2_reg) * (3 * DIM_W)'(cz) + (3 * DIM_W)'(cpz2_reg);
    end

    assign q_push = v2_reg && box2_reg;
    assign q_data = {im2_reg, re2_reg, keep2_reg, idx_full[IDX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg <= '0;
            py_reg <= '0;
            pz_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ax1_reg   <= ax;
        ay1_reg   <= ay;
        az1_reg   <= az;
        re1_reg   <= in_re;
        im1_reg   <= in_im;
        box2_reg  <= ax1_reg.in_box && ay1_reg.in_box && az1_reg.in_box;
        keep2_reg <= keep;
        rowp2_reg <= rowp;
        cpz2_reg  <= az1_reg.cpos;
        re2_reg   <= re1_reg;
        im2_reg   <= im1_reg;
    end

endmodule

`default_nettype wire

/* sv/fgtp_back.sv */
// Back end: split multiplier pipeline scaling both parts by inv_size / 2^48
// (rounded, saturated, zero if cut). Depends on fgtp_pkg; drains the queue.
`default_nettype none

module fgtp_back #(
    parameter int DATA_WIDTH = fgtp_pkg::DEF_DATA_WIDTH,
    parameter int ODEPTH     = fgtp_pkg::OUT_DEPTH,
    parameter int QW         = fgtp_pkg::IDX_W + 1 + 2 * DATA_WIDTH,
    parameter int OW         = fgtp_pkg::IDX_W + 2 * DATA_WIDTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [fgtp_pkg::INV_W-1:0]  inv_size,
    input  wire logic                        q_empty,
    input  wire logic [QW-1:0]               q_data,
    output logic                             q_pop,
    input  wire logic [$clog2(ODEPTH+1)-1:0] o_count,
    output logic                             o_push,
    output logic      [OW-1:0]               o_data
);

    import fgtp_pkg::*;

    localparam int OCNT_W = $clog2(ODEPTH + 1);
    localparam int PP_W   = 2 * HALF_W;
    localparam int SUM_W  = 2 * INV_W;
    localparam logic [INV_W-1:0] SIGN_MAG = INV_W'(1) << (DATA_WIDTH - 1);

    typedef struct packed {
        logic [PP_W-1:0] p00;
        logic [PP_W-1:0] p01;
        logic [PP_W-1:0] p10;
        logic [PP_W-1:0] p11;
    } parts_t;

    function automatic parts_t partials(input logic [DATA_WIDTH-1:0] mag,
                                        input logic [INV_W-1:0]      b);
        parts_t           r;
        logic [INV_W-1:0] a;
        a     = INV_W'(mag);
        r.p00 = PP_W'(a[HALF_W-1:0]) * PP_W'(b[HALF_W-1:0]);
        r.p01 = PP_W'(a[HALF_W-1:0]) * PP_W'(b[INV_W-1:HALF_W]);
        r.p10 = PP_W'(a[INV_W-1:HALF_W]) * PP_W'(b[HALF_W-1:0]);
        r.p11 = PP_W'(a[INV_W-1:HALF_W]) * PP_W'(b[INV_W-1:HALF_W]);
        return r;
    endfunction

    function automatic logic [INV_W-1:0] round_sum(input parts_t p);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p.p00) + (SUM_W'(p.p01) << HALF_W) + (SUM_W'(p.p10) << HALF_W)
          + (SUM_W'(p.p11) << PP_W) + (SUM_W'(1) << (INV_W - 1));
        return s[SUM_W-1:INV_W];
    endfunction

    function automatic logic [DATA_WIDTH-1:0] saturate(input logic [INV_W-1:0] mag,
                                                       input logic             neg,
                                                       input logic             keep);
        logic [INV_W-1:0] m;
        logic [INV_W-1:0] r;
        if (neg) begin
            m = (mag > SIGN_MAG) ? SIGN_MAG : mag;
            r = -m;
        end else begin
            m = (mag > SIGN_MAG - INV_W'(1)) ? SIGN_MAG - INV_W'(1) : mag;
            r = m;
        end
        return keep ? r[DATA_WIDTH-1:0] : '0;
    endfunction

    logic [IDX_W-1:0]      q_idx;
    logic                  q_keep;
    logic [DATA_WIDTH-1:0] q_re, q_im;
    logic [OCNT_W+1:0]     load;

    logic                  b1_reg, b2_reg, b3_reg;
    logic [IDX_W-1:0]      idx1_reg, idx2_reg, idx3_reg;
    logic                  keep1_reg, keep2_reg, keep3_reg;
    logic                  nre1_reg, nre2_reg, nre3_reg, nim1_reg, nim2_reg, nim3_reg;
    logic [DATA_WIDTH-1:0] mre1_reg, mim1_reg;
    parts_t                pre2_reg, pim2_reg;
    logic [INV_W-1:0]      mre3_reg, mim3_reg;

    assign q_idx  = q_data[IDX_W-1:0];
    assign q_keep = q_data[IDX_W];
    assign q_re   = q_data[IDX_W+1 +: DATA_WIDTH];
    assign q_im   = q_data[IDX_W+1+DATA_WIDTH +: DATA_WIDTH];

    assign load  = (OCNT_W + 2)'(o_count) + (OCNT_W + 2)'(b1_reg)
                 + (OCNT_W + 2)'(b2_reg) + (OCNT_W + 2)'(b3_reg);
    assign q_pop = !q_empty && (load < (OCNT_W + 2)'(ODEPTH));

    assign o_push = b3_reg;
    assign o_data = {saturate(mim3_reg, nim3_reg, keep3_reg),
                     saturate(mre3_reg, nre3_reg, keep3_reg), idx3_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_reg <= 1'b0;
            b2_reg <= 1'b0;
            b3_reg <= 1'b0;
        end else begin
            b1_reg <= q_pop;
            b2_reg <= b1_reg;
            b3_reg <= b2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg  <= q_idx;
        keep1_reg <= q_keep;
        nre1_reg  <= q_re[DATA_WIDTH-1];
        nim1_reg  <= q_im[DATA_WIDTH-1];
        mre1_reg  <= q_re[DATA_WIDTH-1] ? -q_re : q_re;
        mim1_reg  <= q_im[DATA_WIDTH-1] ? -q_im : q_im;

        idx2_reg  <= idx1_reg;
        keep2_reg <= keep1_reg;
        nre2_reg  <= nre1_reg;
        nim2_reg  <= nim1_reg;
        pre2_reg  <= partials(mre1_reg, inv_size);
        pim2_reg  <= partials(mim1_reg, inv_size);

        idx3_reg  <= idx2_reg;
        keep3_reg <= keep2_reg;
        nre3_reg  <= nre2_reg;
        nim3_reg  <= nim2_reg;
        mre3_reg  <= round_sum(pre2_reg);
        mim3_reg  <= round_sum(pim2_reg);
    end

endmodule

`default_nettype wire

/* sv/fgtp_checker.sv */
// Port-level checker of the grid truncation core and its bind statement.
// Depends on fgtp_pkg and fourier_grid_truncate_pack_core_assert.svh.
`default_nettype none

`include "fourier_grid_truncate_pack_core_assert.svh"

module fgtp_checker #(
    parameter int DATA_WIDTH = fgtp_pkg::DEF_DATA_WIDTH
) (
    input wire logic                                         aclk,
    input wire logic                                         aresetn,
    input wire logic                                         s_tvalid,
    input wire logic                                         s_tready,
    input wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]            s_tdata,
    input wire logic                                         m_tvalid,
    input wire logic                                         m_tready,
    input wire logic [((fgtp_pkg::IDX_W+2*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    input wire logic                                         cfg_valid,
    input wire logic                                         cfg_ready,
    input wire logic [fgtp_pkg::CFG_INDEX_W-1:0]             cfg_index,
    input wire logic [fgtp_pkg::CFG_DATA_W-1:0]              cfg_data
);

    import fgtp_pkg::*;

    logic [31:0] pend_reg, pend_next;
    logic        in_acc, out_acc;
    logic        cfg_seen;

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign cfg_seen = cfg_valid && (cfg_index <= REG_INV_SIZE || cfg_data != '0 || s_tdata != '0);

    always_comb begin
        pend_next = pend_reg + 32'(in_acc) - 32'(out_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // Every result must stem from an input word that is not yet answered.
    `FGTP_ASSERT_SAME(a_result_has_source, aclk, aresetn, m_tvalid, pend_reg != 32'd0,
        "result word without a pending input word")

    `FGTP_ASSERT_SAME(a_cfg_always_ready, aclk, aresetn, cfg_seen || !cfg_seen, cfg_ready,
        "configuration channel not ready")

    `FGTP_ASSERT_NEXT(a_out_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid,
        "output valid dropped while stalled")

    `FGTP_ASSERT_NEXT(a_out_data_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata),
        "output data changed while stalled")

endmodule

bind fourier_grid_truncate_pack_core fgtp_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_fgtp_checker (.*);

`default_nettype wire
